FILE: hdl/bsc_pkg.sv
// Shared types and constants for the box/sphere collision test.
// No dependencies; imported by box_sphere_collision_test and bsc_axis.
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int FIELD_W         = 48;   // packed x,y,z corner or centre
    localparam int RAD_W           = 15;   // sphere radius
    localparam int RSUM_W          = RAD_W + 1;
    localparam int RSQ_W           = 2 * RSUM_W;
    localparam int COORD_WIDTH_DEF = 16;

    // Pair kind; first name is the first shape, second name the second shape.
    typedef enum logic [1:0] {
        MODE_BOX_BOX = 2'd0,
        MODE_BOX_SPH = 2'd1,
        MODE_SPH_BOX = 2'd2,
        MODE_SPH_SPH = 2'd3
    } t_mode;

    // Per-stage load strobes for the axis lanes.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_adv;

endpackage

FILE: hdl/box_sphere_collision_test.sv
// Top level of the box/sphere collision test: five-stage pipeline.
// Depends on bsc_pkg and bsc_axis.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------
//  input   | in        | i_valid / o_stall  | two shapes: kind, corners, radius
//  output  | out       | o_valid / i_stall  | hit bit
//
//  One word is taken per cycle while o_stall is low; each word passes through
//  the five register stages in order:
//  offsets, clamp, square, sum, compare.
//  Reset is synchronous and active low; it clears only the stage valid bits.
//  A stall on the output freezes only the full stages behind it; empty stages
//  keep filling, so words keep entering until the pipeline is full.

module box_sphere_collision_test
    import bsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_first_is_sphere,
    input  logic [FIELD_W-1:0] i_first_low_corner,
    input  logic [FIELD_W-1:0] i_first_high_corner,
    input  logic [RAD_W-1:0]   i_first_radius,
    input  logic               i_second_is_sphere,
    input  logic [FIELD_W-1:0] i_second_low_corner,
    input  logic [FIELD_W-1:0] i_second_high_corner,
    input  logic [RAD_W-1:0]   i_second_radius,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit
);

    localparam int PACK_W = 3 * COORD_WIDTH;
    localparam int PAD_W  = (PACK_W > FIELD_W) ? PACK_W : FIELD_W;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

    // Bits above the 48-bit field read as zero.
    logic [PAD_W-1:0] f_lo_pad, f_hi_pad, s_lo_pad, s_hi_pad;
    assign f_lo_pad = PAD_W'(i_first_low_corner);
    assign f_hi_pad = PAD_W'(i_first_high_corner);
    assign s_lo_pad = PAD_W'(i_second_low_corner);
    assign s_hi_pad = PAD_W'(i_second_high_corner);

    // Stage valid bits and per-stage ready chain.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic ld1, ld2, ld3, ld4, ld5;
    t_adv adv;

    assign rdy5 = !r_v5 || !i_stall;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    // Load a stage only when a word actually moves into it.
    assign ld1 = rdy1 && i_valid;
    assign ld2 = rdy2 && r_v1;
    assign ld3 = rdy3 && r_v2;
    assign ld4 = rdy4 && r_v3;
    assign ld5 = rdy5 && r_v4;

    assign adv.s1 = ld1;
    assign adv.s2 = ld2;
    assign adv.s3 = ld3;

    assign o_stall = !rdy1;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Stage 1 control: classify the pair and form the radius to test against.
    t_mode             n_mode;
    logic [RSUM_W-1:0] n_rad;

    always_comb begin
        case ({i_first_is_sphere, i_second_is_sphere})
            2'b00:   n_mode = MODE_BOX_BOX;
            2'b01:   n_mode = MODE_BOX_SPH;
            2'b10:   n_mode = MODE_SPH_BOX;
            default: n_mode = MODE_SPH_SPH;
        endcase
        case (n_mode)
            MODE_BOX_SPH: n_rad = RSUM_W'(i_second_radius);
            MODE_SPH_BOX: n_rad = RSUM_W'(i_first_radius);
            MODE_SPH_SPH: n_rad = RSUM_W'(i_first_radius) + RSUM_W'(i_second_radius);
            default:      n_rad = '0;
        endcase
    end

    // Three axis lanes: offsets, clamp and square, registered at stages 1 to 3.
    t_mode             r_mode1;
    logic [2:0]        ovl;
    logic [SQ_W-1:0]   sq [3];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        bsc_axis #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_axis (
            .i_clk       (i_clk),
            .i_load      (adv),
            .i_mode_in   (n_mode),
            .i_mode_s1   (r_mode1),
            .i_first_lo  (f_lo_pad[k*COORD_WIDTH +: COORD_WIDTH]),
            .i_first_hi  (f_hi_pad[k*COORD_WIDTH +: COORD_WIDTH]),
            .i_second_lo (s_lo_pad[k*COORD_WIDTH +: COORD_WIDTH]),
            .i_second_hi (s_hi_pad[k*COORD_WIDTH +: COORD_WIDTH]),
            .o_ovl       (ovl[k]),
            .o_sq        (sq[k])
        );
    end

    // Side-band payload carried along the stages.
    logic [RSUM_W-1:0] r_rad1, r_rad2;
    logic              r_isbb2, r_isbb3, r_isbb4;
    logic              r_bb2, r_bb3, r_bb4;
    logic [RSQ_W-1:0]  r_rsq3, r_rsq4;
    logic [SUM_W-1:0]  r_sum4;
    logic              r_hit5;
    logic [RSQ_W-1:0]  n_rsq;
    logic [SUM_W-1:0]  n_sum;
    logic              n_hit;

    assign n_rsq = RSQ_W'(r_rad2) * RSQ_W'(r_rad2);
    assign n_sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

    // Box pairs hit on closed overlap; sphere tests need a strict inside.
    assign n_hit = r_isbb4 ? r_bb4 : (CMP_W'(r_sum4) < CMP_W'(r_rsq4));

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_mode1 <= n_mode;
            r_rad1  <= n_rad;
        end
        if (ld2) begin
            r_rad2  <= r_rad1;
            r_isbb2 <= (r_mode1 == MODE_BOX_BOX);
            r_bb2   <= &ovl;
        end
        if (ld3) begin
            r_rsq3  <= n_rsq;
            r_isbb3 <= r_isbb2;
            r_bb3   <= r_bb2;
        end
        if (ld4) begin
            r_sum4  <= n_sum;
            r_rsq4  <= r_rsq3;
            r_isbb4 <= r_isbb3;
            r_bb4   <= r_bb3;
        end
        if (ld5) begin
            r_hit5 <= n_hit;
        end
    end

    assign o_hit = r_hit5;

endmodule

FILE: hdl/bsc_axis.sv
// One coordinate axis of the collision test: difference, clamp and square.
// Depends on bsc_pkg; instantiated three times by box_sphere_collision_test.
`timescale 1ns / 1ps

module bsc_axis
    import bsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  t_adv                          i_load,
    input  t_mode                         i_mode_in,
    input  t_mode                         i_mode_s1,
    input  logic signed [COORD_WIDTH-1:0] i_first_lo,
    input  logic signed [COORD_WIDTH-1:0] i_first_hi,
    input  logic signed [COORD_WIDTH-1:0] i_second_lo,
    input  logic signed [COORD_WIDTH-1:0] i_second_hi,
    output logic                          o_ovl,
    output logic [2*COORD_WIDTH-1:0]      o_sq
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] lo, hi, ctr;
    logic signed [DW-1:0]          n_a, n_b, r_a, r_b;
    logic signed [DW-1:0]          mn, n_d, r_d;
    logic signed [2*DW-1:0]        n_prod;
    logic                          n_ovl, r_ovl;
    logic [2*COORD_WIDTH-1:0]      r_sq;

    // Stage 1: pick box and centre, take both offsets to the centre and test box overlap.
    always_comb begin
        if (i_mode_in == MODE_SPH_BOX) begin
            lo  = i_second_lo;
            hi  = i_second_hi;
            ctr = i_first_lo;
        end else begin
            lo  = i_first_lo;
            hi  = i_first_hi;
            ctr = i_second_lo;
        end
        n_a   = DW'(lo) - DW'(ctr);
        n_b   = DW'(hi) - DW'(ctr);
        n_ovl = (i_first_lo <= i_second_hi) && (i_first_hi >= i_second_lo);
    end

    // Stage 2: for box/sphere pairs the clamp offset is max(lo - c, min(0, hi - c)); else lo - c.
    always_comb begin
        mn = r_b[DW-1] ? r_b : '0;
        if (i_mode_s1 == MODE_BOX_SPH || i_mode_s1 == MODE_SPH_BOX) begin
            n_d = (r_a > mn) ? r_a : mn;
        end else begin
            n_d = r_a;
        end
    end

    // Stage 3: square.
    assign n_prod = r_d * r_d;

    always_ff @(posedge i_clk) begin
        if (i_load.s1) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_ovl <= n_ovl;
        end
        if (i_load.s2) begin
            r_d <= n_d;
        end
        if (i_load.s3) begin
            r_sq <= n_prod[2*COORD_WIDTH-1:0];
        end
    end

    assign o_ovl = r_ovl;
    assign o_sq  = r_sq;

endmodule

FILE: hdl/bsc_checker.sv
// Port-level checks for box_sphere_collision_test, attached by bind.
// Depends on box_sphere_collision_test ports only.
`timescale 1ns / 1ps

module bsc_port_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit
);

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

    // An empty output stage never backs up the input.
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage is empty");

    // A word leaving frees the whole chain.
    a_drain_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while output word is taken");

    // Hold a stalled result.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit))
        else $error("stalled output word changed");

endmodule

bind box_sphere_collision_test bsc_port_props u_bsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hit   (o_hit)
);
